FILE: rtl/ladder_lowpass_filter_core_macros.svh
// assertion macros shared by the ladder lowpass checker
`ifndef LADDER_LOWPASS_FILTER_CORE_MACROS_SVH
`define LADDER_LOWPASS_FILTER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LLF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define LLF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/llf_pkg.sv
// shared constants, codes and types of the ladder lowpass filter
package llf_pkg;

  // state and internal value width
  localparam int ACC_W = 32;
  // signed coefficient operand wide enough for every register
  localparam int COEF_W = 26;

  // defaults of the top level parameters
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 22;

  // configuration register widths
  localparam int STAGE_GAIN_W  = 23;
  localparam int POLE_COEF_W   = 24;
  localparam int GAIN_FOURTH_W = 23;
  localparam int RESONANCE_W   = 25;
  localparam int OUTPUT_NORM_W = 23;
  localparam int CFG_DATA_W    = 25;
  localparam int CFG_ADDR_W    = 3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_STAGE_GAIN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_POLE_COEF   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_FOURTH = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RESONANCE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_NORM = 3'd4;

  // configuration reset values
  localparam logic [POLE_COEF_W-1:0]   POLE_COEF_RST   = 24'hC00000;
  localparam logic [OUTPUT_NORM_W-1:0] OUTPUT_NORM_RST = 23'h400000;

  // micro-steps of one item, one product each
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_P1 = 4'd0;   // p = s2 + b*s1
  localparam logic [STEP_W-1:0] ST_P2 = 4'd1;   // p = s3 + b*p
  localparam logic [STEP_W-1:0] ST_P3 = 4'd2;   // p = s4 + b*p
  localparam logic [STEP_W-1:0] ST_T  = 4'd3;   // p = g4*x + p
  localparam logic [STEP_W-1:0] ST_Y  = 4'd4;   // y = norm*p
  localparam logic [STEP_W-1:0] ST_U  = 4'd5;   // p = x - k*y
  localparam logic [STEP_W-1:0] ST_N1 = 4'd6;   // bu = b*u, n = bu + s1
  localparam logic [STEP_W-1:0] ST_S1 = 4'd7;   // s1 = bu - a*n
  localparam logic [STEP_W-1:0] ST_N2 = 4'd8;
  localparam logic [STEP_W-1:0] ST_S2 = 4'd9;
  localparam logic [STEP_W-1:0] ST_N3 = 4'd10;
  localparam logic [STEP_W-1:0] ST_S3 = 4'd11;
  localparam logic [STEP_W-1:0] ST_B4 = 4'd12;  // bu = b*n3
  localparam logic [STEP_W-1:0] ST_S4 = 4'd13;  // s4 = bu - a*y
  localparam logic [STEP_W-1:0] ST_LAST = ST_S4;

  // sequencer strobes to the datapath
  typedef struct packed {
    logic              mul_en;
    logic              acc_en;
    logic [STEP_W-1:0] step;
  } llf_ctrl_t;

endpackage

FILE: rtl/llf_mac.sv
// shared multiply-round unit with saturating add or subtract
module llf_mac #(
  parameter int COEF_FRAC_BITS = llf_pkg::COEF_FRAC_BITS_DEF,
  parameter int ADD_W          = 37,
  parameter int RND_W          = 36
) (
  input  logic                            clk_i,
  input  logic                            mul_en_i,
  input  logic signed [llf_pkg::ACC_W-1:0]  val_i,
  input  logic signed [llf_pkg::COEF_W-1:0] coef_i,
  input  logic signed [ADD_W-1:0]          addend_i,
  input  logic                            sub_i,
  output logic signed [RND_W-1:0]          prod_o,
  output logic signed [llf_pkg::ACC_W-1:0]  sum_o
);
  import llf_pkg::*;

  localparam int PW  = ACC_W + COEF_W;
  localparam int SW  = ADD_W + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (COEF_FRAC_BITS - 1);

  logic signed [PW-1:0]    prod_d;
  logic signed [PW-1:0]    prod_q;
  logic signed [SW-1:0]    a_ext;
  logic signed [SW-1:0]    m_ext;
  logic signed [SW-1:0]    sum;
  logic [SW-ACC_W:0]       hi;

  // product plus rounding half, registered
  assign prod_d = PW'(val_i) * PW'(coef_i) + HALF;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // floor shift gives round half up
  assign prod_o = prod_q[PW-1:COEF_FRAC_BITS];

  // add or subtract against the selected operand
  assign a_ext = SW'(addend_i);
  assign m_ext = SW'(prod_o);
  assign sum   = sub_i ? (a_ext - m_ext) : (a_ext + m_ext);

  // saturate to the signed state range
  assign hi = sum[SW-1:ACC_W-1];
  always_comb begin
    if ((&hi) || !(|hi)) begin
      sum_o = sum[ACC_W-1:0];
    end else if (sum[SW-1]) begin
      sum_o = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sum_o = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

endmodule

FILE: rtl/llf_seq.sv
// step sequencer: a multiply state and an accumulate state per step
module llf_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               hold_i,
  output llf_pkg::llf_ctrl_t ctrl_o,
  output logic               idle_o,
  output logic               done_o
);
  import llf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              last;
  logic              stall;

  assign last  = (step_q == ST_LAST);
  // last write waits while the previous result is still unread
  assign stall = (state_q == S_ACC) && last && hold_i;

  // next state and step
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_MUL;
          step_d  = ST_P1;
        end
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (last) begin
          if (!hold_i) begin
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_MUL;
          step_d  = step_q + STEP_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= ST_P1;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // strobes
  assign ctrl_o.mul_en = (state_q == S_MUL);
  assign ctrl_o.acc_en = (state_q == S_ACC) && !stall;
  assign ctrl_o.step   = step_q;
  assign idle_o        = (state_q == S_IDLE);
  assign done_o        = (state_q == S_ACC) && last && !hold_i;

endmodule

FILE: rtl/ladder_lowpass_filter_core.sv
// four-stage zero-delay-feedback ladder lowpass, top level
// the result is registered at the output as the last step is written back
// fourteen products per item through the one shared multiplier, each taking
//   a multiply state and an accumulate state
// the input is taken again as soon as the sequencer is idle, while a result waits
// reset: stage states clear to zero, registers take their reset values
module ladder_lowpass_filter_core #(
  parameter int SAMPLE_BITS    = llf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = llf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [llf_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [llf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,  // sample_in
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata   // sample_out
);
  import llf_pkg::*;

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int RND_W   = ACC_W + COEF_W - COEF_FRAC_BITS;
  localparam int ADD_W   = (RND_W > ACC_W) ? RND_W : ACC_W;
  localparam logic signed [ACC_W-1:0] SMAX = 32'sh7FFFFFFF >>> (ACC_W - SAMPLE_BITS);
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

  // configuration registers
  logic [STAGE_GAIN_W-1:0]  stage_gain_q;
  logic [POLE_COEF_W-1:0]   pole_coef_q;
  logic [GAIN_FOURTH_W-1:0] gain_fourth_q;
  logic [RESONANCE_W-1:0]   resonance_q;
  logic [OUTPUT_NORM_W-1:0] output_norm_q;

  // filter state and working registers
  logic signed [ACC_W-1:0]       s1_q, s2_q, s3_q, s4_q;
  logic signed [ACC_W-1:0]       p_q, y_q, n_q;
  logic signed [RND_W-1:0]       bu_q;
  logic signed [SAMPLE_BITS-1:0] x_q;

  // output register
  logic                          out_valid_q;
  logic [SAMPLE_BITS-1:0]        out_data_q;
  logic signed [ACC_W-1:0]       y_clamp;

  // datapath wiring
  llf_ctrl_t                  ctrl;
  logic                       idle;
  logic                       done;
  logic                       in_acc;
  logic                       out_busy;
  logic signed [ACC_W-1:0]    val;
  logic signed [COEF_W-1:0]   coef;
  logic signed [ADD_W-1:0]    addend;
  logic                       sub;
  logic signed [RND_W-1:0]    prod;
  logic signed [ACC_W-1:0]    sum;
  logic signed [COEF_W-1:0]   b_c, a_c, g4_c, k_c, norm_c;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_busy = out_valid_q && !m_axis_tready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_gain_q  <= '0;
      pole_coef_q   <= POLE_COEF_RST;
      gain_fourth_q <= '0;
      resonance_q   <= '0;
      output_norm_q <= OUTPUT_NORM_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_STAGE_GAIN:  stage_gain_q  <= cfg_wdata_i[STAGE_GAIN_W-1:0];
        REG_POLE_COEF:   pole_coef_q   <= cfg_wdata_i[POLE_COEF_W-1:0];
        REG_GAIN_FOURTH: gain_fourth_q <= cfg_wdata_i[GAIN_FOURTH_W-1:0];
        REG_RESONANCE:   resonance_q   <= cfg_wdata_i[RESONANCE_W-1:0];
        REG_OUTPUT_NORM: output_norm_q <= cfg_wdata_i[OUTPUT_NORM_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficients as signed operands
  assign b_c    = COEF_W'(signed'({1'b0, stage_gain_q}));
  assign a_c    = COEF_W'(signed'(pole_coef_q));
  assign g4_c   = COEF_W'(signed'({1'b0, gain_fourth_q}));
  assign k_c    = COEF_W'(signed'({1'b0, resonance_q}));
  assign norm_c = COEF_W'(signed'({1'b0, output_norm_q}));

  // operand selection per step
  always_comb begin
    val    = p_q;
    coef   = b_c;
    addend = '0;
    sub    = 1'b0;
    case (ctrl.step)
      ST_P1: begin val = s1_q;  coef = b_c;  addend = ADD_W'(s2_q); end
      ST_P2: begin val = p_q;   coef = b_c;  addend = ADD_W'(s3_q); end
      ST_P3: begin val = p_q;   coef = b_c;  addend = ADD_W'(s4_q); end
      ST_T:  begin val = ACC_W'(x_q); coef = g4_c; addend = ADD_W'(p_q); end
      ST_Y:  begin val = p_q;   coef = norm_c; end
      ST_U:  begin
        val = y_q;  coef = k_c;  addend = ADD_W'(x_q);  sub = 1'b1;
      end
      ST_N1: begin val = p_q;   coef = b_c;  addend = ADD_W'(s1_q); end
      ST_S1: begin val = n_q;   coef = a_c;  addend = ADD_W'(bu_q); sub = 1'b1; end
      ST_N2: begin val = n_q;   coef = b_c;  addend = ADD_W'(s2_q); end
      ST_S2: begin val = n_q;   coef = a_c;  addend = ADD_W'(bu_q); sub = 1'b1; end
      ST_N3: begin val = n_q;   coef = b_c;  addend = ADD_W'(s3_q); end
      ST_S3: begin val = n_q;   coef = a_c;  addend = ADD_W'(bu_q); sub = 1'b1; end
      ST_B4: begin val = n_q;   coef = b_c; end
      ST_S4: begin val = y_q;   coef = a_c;  addend = ADD_W'(bu_q); sub = 1'b1; end
      default: ;
    endcase
  end

  llf_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .hold_i  (out_busy),
    .ctrl_o  (ctrl),
    .idle_o  (idle),
    .done_o  (done)
  );

  llf_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .ADD_W          (ADD_W),
    .RND_W          (RND_W)
  ) u_mac (
    .clk_i    (clk_i),
    .mul_en_i (ctrl.mul_en),
    .val_i    (val),
    .coef_i   (coef),
    .addend_i (addend),
    .sub_i    (sub),
    .prod_o   (prod),
    .sum_o    (sum)
  );

  // input sample capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
  end

  // working values written back by step
  always_ff @(posedge clk_i) begin
    if (ctrl.acc_en) begin
      case (ctrl.step)
        ST_P1, ST_P2, ST_P3, ST_T, ST_U: p_q <= sum;
        ST_Y: y_q <= sum;
        ST_N1, ST_N2, ST_N3: begin
          n_q  <= sum;
          bu_q <= prod;
        end
        ST_B4: bu_q <= prod;
        default: ;
      endcase
    end
  end

  // stage states
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
    end else if (ctrl.acc_en) begin
      case (ctrl.step)
        ST_S1: s1_q <= sum;
        ST_S2: s2_q <= sum;
        ST_S3: s3_q <= sum;
        ST_S4: s4_q <= sum;
        default: ;
      endcase
    end
  end

  // clamp to the sample range
  always_comb begin
    if (y_q > SMAX) begin
      y_clamp = SMAX;
    end else if (y_q < SMIN) begin
      y_clamp = SMIN;
    end else begin
      y_clamp = y_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= y_clamp[SAMPLE_BITS-1:0];
    end
  end

  assign s_axis_tready = idle;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_data_q);

endmodule

FILE: rtl/llf_checker.sv
// port-level checks of the ladder lowpass, bound to the top level
`include "ladder_lowpass_filter_core_macros.svh"

module llf_checker #(
  parameter int SAMPLE_BITS = llf_pkg::SAMPLE_BITS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

  // a taken item keeps the block busy
  `LLF_ASSERT_NXT(busy_after_take, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready ##1 !s_axis_tready, "input taken again too early")

  // a new result appears only as the sequencer returns to idle
  `LLF_ASSERT_NOW(result_at_idle, clk_i, rst_ni, $rose(m_axis_tvalid), s_axis_tready, "result without finishing the item")

  // the block frees its input only when it has a result to show
  `LLF_ASSERT_NOW(ready_with_result, clk_i, rst_ni, $rose(s_axis_tready), m_axis_tvalid, "input freed with no result")

  // an unread result holds its value
  `LLF_ASSERT_NXT(result_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "unread result dropped or changed")

endmodule

bind ladder_lowpass_filter_core llf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_llf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: test/tb_top.sv
// self-checking testbench for the four-stage ladder lowpass core
module tb_top;
  import llf_pkg::*;

  localparam int SB   = SAMPLE_BITS_DEF;
  localparam int FRAC = COEF_FRAC_BITS_DEF;
  localparam int DW   = ((SB + 7) / 8) * 8;

  localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [CFG_DATA_W-1:0] ONE_Q = CFG_DATA_W'(1) << FRAC;

  localparam int RANDOM_ITEMS  = 650;
  localparam int MAX_GAP       = 19;
  localparam int HOLD_CYCLES   = 300;
  // quiet cycles between phases before the coefficients change
  localparam int SETTLE_CYCLES = 32;

  typedef enum int {WAVE_NOISE, WAVE_SCALED, WAVE_SQUARE} wave_e;
  typedef enum int {CFG_TUNED, CFG_RAW, CFG_CORNER} cfg_kind_e;

  // mirror of the filter: coefficients, stage states and outputs still owed
  class ladder_book;
    longint gain_b = 0;
    longint pole_a = longint'($signed(POLE_COEF_RST));
    longint gain4  = 0;
    longint reso   = 0;
    longint norm   = longint'(OUTPUT_NORM_RST);
    longint s1 = 0, s2 = 0, s3 = 0, s4 = 0;
    logic [DW-1:0] pending_out[$];
    int fails = 0;

    static function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // value times coefficient, rounded half up
    static function longint mulq(longint v, longint c);
      return (v * c + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_STAGE_GAIN:  gain_b = longint'(val[STAGE_GAIN_W-1:0]);
        REG_POLE_COEF:   pole_a = longint'($signed(val[POLE_COEF_W-1:0]));
        REG_GAIN_FOURTH: gain4  = longint'(val[GAIN_FOURTH_W-1:0]);
        REG_RESONANCE:   reso   = longint'(val[RESONANCE_W-1:0]);
        REG_OUTPUT_NORM: norm   = longint'(val[OUTPUT_NORM_W-1:0]);
        default: ;
      endcase
    endfunction

    // one sample through the ladder, output queued for checking
    function void take_sample(logic [SB-1:0] raw);
      longint x, p, y, u, bu, n1, n2, n3, o;
      logic [DW-1:0] want;
      x = longint'($signed(raw));
      // prediction from the stage states
      p = sat32(s2 + mulq(s1, gain_b));
      p = sat32(s3 + mulq(p, gain_b));
      p = sat32(s4 + mulq(p, gain_b));
      y = sat32(mulq(sat32(mulq(x, gain4) + p), norm));
      u = sat32(x - mulq(y, reso));
      // cascaded one-pole stages
      bu = mulq(u, gain_b);
      n1 = sat32(bu + s1);
      s1 = sat32(bu - mulq(n1, pole_a));
      bu = mulq(n1, gain_b);
      n2 = sat32(bu + s2);
      s2 = sat32(bu - mulq(n2, pole_a));
      bu = mulq(n2, gain_b);
      n3 = sat32(bu + s3);
      s3 = sat32(bu - mulq(n3, pole_a));
      s4 = sat32(mulq(n3, gain_b) - mulq(y, pole_a));
      // clamp to the sample range
      o = y;
      if (o > longint'($signed(S_MAX))) o = longint'($signed(S_MAX));
      if (o < longint'($signed(S_MIN))) o = longint'($signed(S_MIN));
      want = '0;
      want[SB-1:0] = o[SB-1:0];
      pending_out.push_back(want);
    endfunction

    function void check_sample(logic [DW-1:0] got);
      logic [DW-1:0] want;
      if (pending_out.size() == 0) begin
        $error("sample_out: no result expected, got %0d", $signed(got[SB-1:0]));
        fails++;
        return;
      end
      want = pending_out.pop_front();
      if (got !== want) begin
        $error("sample_out: expected %0d, got %0d",
               $signed(want[SB-1:0]), $signed(got[SB-1:0]));
        fails++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;   // sample_in
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [DW-1:0] m_axis_tdata;        // sample_out

  ladder_book book = new;
  logic [SB-1:0] stim_q[$];

  ladder_lowpass_filter_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watch both handshakes
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) book.take_sample(s_axis_tdata[SB-1:0]);
    if (rst_ni && m_axis_tvalid && m_axis_tready) book.check_sample(m_axis_tdata);
  end

  // one register write, mirrored in the predictor
  task automatic write_coef(input logic [CFG_ADDR_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    book.write_reg(idx, val);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] b, input logic [CFG_DATA_W-1:0] a,
                            input logic [CFG_DATA_W-1:0] g4, input logic [CFG_DATA_W-1:0] k,
                            input logic [CFG_DATA_W-1:0] nrm);
    write_coef(REG_STAGE_GAIN, b);
    write_coef(REG_POLE_COEF, a);
    write_coef(REG_GAIN_FOURTH, g4);
    write_coef(REG_RESONANCE, k);
    write_coef(REG_OUTPUT_NORM, nrm);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offer one sample after a gap; called at a clock edge
  task automatic send_sample(input logic [SB-1:0] x, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DW'(x);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // take one result after a stall
  task automatic take_result(input int gap);
    if (gap > 0) begin
      m_axis_tready <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
    do @(posedge clk_i); while (!m_axis_tvalid);
  endtask

  // stream the queued samples through and collect every result
  task automatic run_phase(input bit send_gaps, input bit take_gaps, input int hold);
    int n;
    n = stim_q.size();
    @(posedge clk_i);
    fork
      begin
        for (int i = 0; i < n; i++)
          send_sample(stim_q[i], send_gaps ? $urandom_range(0, MAX_GAP) : 0);
        s_axis_tvalid <= 1'b0;
      end
      begin
        if (hold > 0) begin
          m_axis_tready <= 1'b0;
          repeat (hold) @(posedge clk_i);
        end
        for (int i = 0; i < n; i++)
          take_result(take_gaps ? $urandom_range(0, MAX_GAP) : 0);
      end
    join
    stim_q.delete();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [SB-1:0] make_sample(wave_e kind, int idx, int amp_bits, int period);
    int r;
    r = $urandom();
    case (kind)
      WAVE_NOISE:  return SB'(r);
      WAVE_SCALED: return SB'(r >>> (32 - amp_bits));
      default:     return ((idx / period) % 2) ? SB'((1 << (amp_bits - 1)) - 1)
                                               : SB'(-(1 << (amp_bits - 1)));
    endcase
  endfunction

  // zero, top of the field, or its sign bit alone
  function automatic logic [CFG_DATA_W-1:0] corner_value(int width, bit is_signed);
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return is_signed ? (CFG_DATA_W'(1) << (width - 1)) - 1
                                : (CFG_DATA_W'(1) << width) - 1;
      default: return CFG_DATA_W'(1) << (width - 1);
    endcase
  endfunction

  initial begin
    int done, phase, n, amp_bits, period, b_q;
    real br, b4, k_real;
    logic [CFG_DATA_W-1:0] k_q;
    wave_e wave;
    cfg_kind_e ckind;
    done  = 0;
    phase = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset coefficients: output stays at zero
    stim_q = '{S_MAX, S_MIN, SB'(0)};
    run_phase(1'b0, 1'b0, 0);

    // half gain, no feedback
    set_config(ONE_Q / 2, '0, ONE_Q / 16, '0, ONE_Q);
    stim_q = '{S_MAX, S_MIN, SB'(1), {SB{1'b1}}, SB'(0)};
    run_phase(1'b1, 1'b1, 0);

    // every register at the top of its field: saturation everywhere
    set_config(CFG_DATA_W'({STAGE_GAIN_W{1'b1}}), CFG_DATA_W'({1'b0, {(POLE_COEF_W-1){1'b1}}}),
               CFG_DATA_W'({GAIN_FOURTH_W{1'b1}}), {RESONANCE_W{1'b1}},
               CFG_DATA_W'({OUTPUT_NORM_W{1'b1}}));
    stim_q = '{S_MAX, S_MAX, S_MIN, S_MIN, SB'(0), S_MAX, S_MIN};
    run_phase(1'b1, 1'b0, 0);

    // most negative pole, output clamped; writes past the register list ignored
    set_config(CFG_DATA_W'({STAGE_GAIN_W{1'b1}}), CFG_DATA_W'({1'b1, {(POLE_COEF_W-1){1'b0}}}),
               CFG_DATA_W'({GAIN_FOURTH_W{1'b1}}), '0, CFG_DATA_W'({OUTPUT_NORM_W{1'b1}}));
    for (int i = int'(REG_OUTPUT_NORM) + 1; i < (1 << CFG_ADDR_W); i++)
      write_coef(CFG_ADDR_W'(i), '1);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    stim_q = '{S_MAX, S_MIN, SB'(24'h555555), SB'(24'hAAAAAA), SB'(1)};
    run_phase(1'b0, 1'b1, 0);

    // random phases, mostly with coefficients tuned as software would set them
    while (done < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        7, 8:    ckind = CFG_RAW;
        9:       ckind = CFG_CORNER;
        default: ckind = CFG_TUNED;
      endcase
      case (ckind)
        CFG_TUNED: begin
          b_q    = $urandom_range(0, int'(ONE_Q));
          br     = b_q / real'(ONE_Q);
          b4     = br * br * br * br;
          k_q    = CFG_DATA_W'($urandom_range(0, 4 * int'(ONE_Q)));
          k_real = k_q / real'(ONE_Q);
          set_config(CFG_DATA_W'(b_q), CFG_DATA_W'(2 * b_q - int'(ONE_Q)),
                     CFG_DATA_W'($rtoi(b4 * ONE_Q + 0.5)), k_q,
                     CFG_DATA_W'($rtoi(ONE_Q / (1.0 + b4 * k_real) + 0.5)));
        end
        CFG_RAW:
          set_config(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                     CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
        default:
          set_config(corner_value(STAGE_GAIN_W, 1'b0), corner_value(POLE_COEF_W, 1'b1),
                     corner_value(GAIN_FOURTH_W, 1'b0), corner_value(RESONANCE_W, 1'b0),
                     corner_value(OUTPUT_NORM_W, 1'b0));
      endcase

      wave     = wave_e'($urandom_range(0, 2));
      amp_bits = $urandom_range(2, SB);
      period   = $urandom_range(1, 64);
      n        = (phase == 0) ? 40 : $urandom_range(10, 50);
      for (int i = 0; i < n; i++) stim_q.push_back(make_sample(wave, i, amp_bits, period));

      // first phase: receiver holds off while the sender keeps offering
      if (phase == 0) run_phase(1'b0, 1'b0, HOLD_CYCLES);
      else            run_phase(($urandom_range(0, 1) != 0), ($urandom_range(0, 1) != 0), 0);
      done += n;
      phase++;
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (book.pending_out.size() != 0) begin
      $error("sample_out: %0d expected results never arrived", book.pending_out.size());
      book.fails++;
    end
    if (book.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
